// File: rtl/core/lsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpen core.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int LSH_MAX_WIDTH    = 1024;
  localparam int LSH_MAX_HEIGHT   = 1024;
  localparam int LSH_MAX_CHANNELS = 4;

  localparam int SAMPLE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int SHARP_GAIN = 5;

  localparam logic [10:0] RST_IMG_WIDTH  = 11'd640;
  localparam logic [10:0] RST_IMG_HEIGHT = 11'd480;
  localparam logic [2:0]  RST_CHANNELS   = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH  = 2'd0,
    CFG_IMG_HEIGHT = 2'd1,
    CFG_CHANNELS   = 2'd2
  } lsh_cfg_idx_t;

  // per-item control, raster position decoded at input
  typedef struct packed {
    logic has_res;    // row >= 1: item yields the result for the row above
    logic interior;   // stencil result, else border zero
    logic two_res;    // last row: extra zero result for its own place
    logic frame_end;  // extra result is the final sample of the frame
    logic bank_sel;   // line store written by this item
  } lsh_item_t;

endpackage : lsh_pkg
`default_nettype wire

// File: rtl/core/lsh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_ram
// Generic RAM, one write port, two read ports, registered read (read-first).
// ----------------------------------------------------------------------------
module lsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule : lsh_ram
`default_nettype wire

// File: rtl/core/lsh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_ctrl
// Config registers, raster position counters and item decode.
// ----------------------------------------------------------------------------
module lsh_ctrl
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH    = LSH_MAX_WIDTH,
  parameter int MAX_HEIGHT   = LSH_MAX_HEIGHT,
  parameter int MAX_CHANNELS = LSH_MAX_CHANNELS,
  parameter int S_W   = $clog2(MAX_WIDTH * MAX_CHANNELS),
  parameter int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       cfg_ready,
  input  wire logic                  in_accept,
  output lsh_item_t                  item,
  output logic      [S_W-1:0]        col_addr,
  output logic      [S_W-1:0]        right_addr,
  output logic      [CH_IW-1:0]      chan_lag
);

  localparam int RL_W = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
  localparam int R_W  = $clog2(MAX_HEIGHT);
  localparam int H_W  = $clog2(MAX_HEIGHT + 1);
  localparam int W_W  = $clog2(MAX_WIDTH + 1);
  localparam int C_W  = $clog2(MAX_CHANNELS + 1);

  logic [10:0]    img_width_r;
  logic [10:0]    img_height_r;
  logic [2:0]     channels_r;
  logic [S_W-1:0] col_r, col_nxt;
  logic [R_W-1:0] row_r, row_nxt;
  logic           sel_r, sel_nxt;

  logic [W_W-1:0]  w_eff;
  logic [H_W-1:0]  h_eff;
  logic [C_W-1:0]  c_eff;
  logic [RL_W-1:0] row_len;
  logic [RL_W-1:0] col_ext;
  logic [RL_W-1:0] c_ext;
  logic [H_W-1:0]  row_ext;
  logic            cfg_fire;
  logic            cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  // only a write to an existing register restarts the frame
  assign cfg_hit   = cfg_fire &&
                     (cfg_index inside {CFG_IMG_WIDTH, CFG_IMG_HEIGHT, CFG_CHANNELS});

  // saturate the programmed geometry into the supported range
  always_comb begin
    if (img_width_r < 11'd3) begin
      w_eff = W_W'(3);
    end else if (32'(img_width_r) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(img_width_r);
    end
    if (img_height_r < 11'd3) begin
      h_eff = H_W'(3);
    end else if (32'(img_height_r) > MAX_HEIGHT) begin
      h_eff = H_W'(MAX_HEIGHT);
    end else begin
      h_eff = H_W'(img_height_r);
    end
    if (channels_r == 3'd0) begin
      c_eff = C_W'(1);
    end else if (32'(channels_r) > MAX_CHANNELS) begin
      c_eff = C_W'(MAX_CHANNELS);
    end else begin
      c_eff = C_W'(channels_r);
    end
  end

  assign row_len  = RL_W'(RL_W'(w_eff) * RL_W'(c_eff));
  assign col_ext  = RL_W'(col_r);
  assign c_ext    = RL_W'(c_eff);
  assign row_ext  = H_W'(row_r);
  assign chan_lag = CH_IW'(c_eff - C_W'(1));

  assign col_addr   = col_r;
  assign right_addr = S_W'(col_ext + c_ext);

  always_comb begin
    item.has_res   = (row_r != '0);
    item.interior  = (row_ext >= H_W'(2)) && (col_ext >= c_ext) &&
                     (col_ext < (row_len - c_ext));
    item.two_res   = (row_ext == (h_eff - H_W'(1)));
    item.frame_end = item.two_res && (col_ext == (row_len - RL_W'(1)));
    item.bank_sel  = sel_r;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    sel_nxt = sel_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
      sel_nxt = 1'b0;
    end else if (in_accept) begin
      if ((col_ext + RL_W'(1)) >= row_len) begin
        col_nxt = '0;
        if ((row_ext + H_W'(1)) >= h_eff) begin
          row_nxt = '0;
          sel_nxt = 1'b0;
        end else begin
          row_nxt = row_r + R_W'(1);
          sel_nxt = ~sel_r;
        end
      end else begin
        col_nxt = col_r + S_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= RST_IMG_WIDTH;
      img_height_r <= RST_IMG_HEIGHT;
      channels_r   <= RST_CHANNELS;
      col_r        <= '0;
      row_r        <= '0;
      sel_r        <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sel_r <= sel_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_IMG_WIDTH:  img_width_r  <= cfg_data;
          CFG_IMG_HEIGHT: img_height_r <= cfg_data;
          CFG_CHANNELS:   channels_r   <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule : lsh_ctrl
`default_nettype wire

// File: rtl/core/lsh_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_stencil
// Stencil stage after the line-store read, clamp, and output register with a
// one-deep hold for the extra last-row result.
// ----------------------------------------------------------------------------
module lsh_stencil
  import lsh_pkg::*;
#(
  parameter int MAX_CHANNELS = LSH_MAX_CHANNELS,
  parameter int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_accept,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire lsh_item_t           in_item,
  output logic                     in_ready,
  input  wire logic [CH_IW-1:0]    chan_lag,
  // registered line-store reads for the item in this stage
  input  wire logic [SAMPLE_W-1:0] bank0_col,
  input  wire logic [SAMPLE_W-1:0] bank0_right,
  input  wire logic [SAMPLE_W-1:0] bank1_col,
  input  wire logic [SAMPLE_W-1:0] bank1_right,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_sample,
  output logic                     out_last
);

  logic                v1_r, v1_nxt;
  lsh_item_t           item1_r;
  logic [SAMPLE_W-1:0] down1_r;
  logic [SAMPLE_W-1:0] ctr_hist_r [MAX_CHANNELS];

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_last_r, pend_last_nxt;

  logic [SAMPLE_W-1:0] ctr, up, rgt, lft;
  logic [10:0]         gain_v;
  logic [9:0]          nsum;
  logic signed [11:0]  diff;
  logic [SAMPLE_W-1:0] res;
  logic                slot_free;
  logic                adv1;

  // bank_sel holds the row being written: the other bank is the center row
  always_comb begin
    if (item1_r.bank_sel) begin
      up  = bank1_col;
      ctr = bank0_col;
      rgt = bank0_right;
    end else begin
      up  = bank0_col;
      ctr = bank1_col;
      rgt = bank1_right;
    end
  end

  // left neighbor: center read of the item one pixel back
  assign lft    = ctr_hist_r[chan_lag];
  assign gain_v = 11'(ctr) * 11'(SHARP_GAIN);
  assign nsum   = 10'(lft) + 10'(rgt) + 10'(up) + 10'(down1_r);
  assign diff   = $signed({1'b0, gain_v}) - $signed({2'b00, nsum});

  always_comb begin
    if (!item1_r.interior || diff < 12'sd0) begin
      res = '0;
    end else if (diff > 12'sd255) begin
      res = '1;
    end else begin
      res = diff[SAMPLE_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign adv1      = v1_r && (!item1_r.has_res || (slot_free && !pend_r));
  assign in_ready  = !v1_r || adv1;

  always_comb begin
    v1_nxt        = v1_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    if (in_accept) begin
      v1_nxt = 1'b1;
    end else if (adv1) begin
      v1_nxt = 1'b0;
    end
    if (slot_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_last_nxt  = pend_last_r;
        pend_nxt      = 1'b0;
      end else if (adv1 && item1_r.has_res) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
        out_last_nxt  = 1'b0;
        pend_nxt      = item1_r.two_res;
        pend_last_nxt = item1_r.frame_end;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    pend_last_r <= pend_last_nxt;
    if (in_accept) begin
      item1_r <= in_item;
      down1_r <= in_sample;
    end
    if (adv1) begin
      ctr_hist_r[0] <= ctr;
      for (int k = 1; k < MAX_CHANNELS; k++) begin
        ctr_hist_r[k] <= ctr_hist_r[k-1];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;
  assign out_last   = out_last_r;

endmodule : lsh_stencil
`default_nettype wire

// File: rtl/core/laplacian_sharpen_3x3_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_core
// 3x3 Laplacian sharpen over a raster stream of interleaved 8-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per item, raster order, channels interleaved.
//   out_* : sharpened samples, raster order, one row behind the input.
//           tlast marks the final sample of the frame.
//   cfg_* : register writes (0 width, 1 height, 2 channels), always ready.
//           A write to 0-2 restarts the frame; write only while the core is idle.
// Each item of row r >= 1 gives the result for row r-1 at the same place;
// items of the first row give none, items of the last row give a second,
// zero result for their own place. Border rows and columns come out zero.
// Throughput: one item per cycle while the output takes results, set by the
// single pass through the two line-store banks (two reads each, one write in
// the bank taking the row). A last-row item gives two results; an item with
// a result behind it waits. Results pass the stage and output registers.
// Reset clears position counters and pipeline valids, loads the default
// geometry; line-store contents are left as they are. When out_tready is low
// with a result waiting, the output register holds, an item with a result in
// the stage behind it waits, and in_tready drops.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_core
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH    = LSH_MAX_WIDTH,
  parameter int MAX_HEIGHT   = LSH_MAX_HEIGHT,
  parameter int MAX_CHANNELS = LSH_MAX_CHANNELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] pixel_sample
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [7:0]            out_tdata,  // [7:0] sharp_sample
  output logic                       out_tlast,  // frame_last
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_HALF = MAX_WIDTH * MAX_CHANNELS;
  localparam int S_W        = $clog2(STORE_HALF);
  localparam int CH_IW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                in_accept;
  lsh_item_t           item0;
  logic [S_W-1:0]      col_addr;
  logic [S_W-1:0]      right_addr;
  logic [CH_IW-1:0]    chan_lag;
  logic [SAMPLE_W-1:0] b0_col, b0_right, b1_col, b1_right;

  assign in_accept = in_tvalid & in_tready;

  lsh_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .S_W          (S_W),
    .CH_IW        (CH_IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .in_accept  (in_accept),
    .item       (item0),
    .col_addr   (col_addr),
    .right_addr (right_addr),
    .chan_lag   (chan_lag)
  );

  // Two line-store banks. The bank taking the current row also supplies the
  // row above the center (read-first at the written address); the other
  // bank holds the center row and supplies center and right neighbor.
  lsh_ram #(
    .WIDTH  (SAMPLE_W),
    .DEPTH  (STORE_HALF),
    .ADDR_W (S_W)
  ) u_bank0 (
    .clk     (clk),
    .we      (in_accept & ~item0.bank_sel),
    .waddr   (col_addr),
    .wdata   (in_tdata),
    .re      (in_accept),
    .raddr_a (col_addr),
    .raddr_b (right_addr),
    .rdata_a (b0_col),
    .rdata_b (b0_right)
  );

  lsh_ram #(
    .WIDTH  (SAMPLE_W),
    .DEPTH  (STORE_HALF),
    .ADDR_W (S_W)
  ) u_bank1 (
    .clk     (clk),
    .we      (in_accept & item0.bank_sel),
    .waddr   (col_addr),
    .wdata   (in_tdata),
    .re      (in_accept),
    .raddr_a (col_addr),
    .raddr_b (right_addr),
    .rdata_a (b1_col),
    .rdata_b (b1_right)
  );

  lsh_stencil #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_IW        (CH_IW)
  ) u_stencil (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_sample   (in_tdata),
    .in_item     (item0),
    .in_ready    (in_tready),
    .chan_lag    (chan_lag),
    .bank0_col   (b0_col),
    .bank0_right (b0_right),
    .bank1_col   (b1_col),
    .bank1_right (b1_right),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (out_tdata),
    .out_last    (out_tlast)
  );

endmodule : laplacian_sharpen_3x3_core
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for laplacian_sharpen_3x3_core. A queue-fed driver
// streams 8-bit samples in raster order. A line-buffered predictor computes
// the sharpened result items and the frame-end flag for each sample. A
// monitor checks every output item against the oldest expected one.
// Geometry is reprogrammed between frames, with in-range and clamped
// register values. The run goes through four handshake pressure modes.
// ----------------------------------------------------------------------------
module tb_top
  import lsh_pkg::*;
;

  localparam int LIMIT_CYCLES  = 600_000;
  localparam int SETTLE_CYCLES = 8;     // covers the two-stage pipe plus margin
  localparam int SHOW_MAX      = 10;
  localparam int PHASE_ITEMS   = 120;
  localparam int LINE_HALF     = LSH_MAX_WIDTH * LSH_MAX_CHANNELS;
  // index with no register behind it: a write there must not restart the frame
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sharp_res_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  laplacian_sharpen_3x3_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: raw register values, two line banks, raster position
  // --------------------------------------------------------------------------
  logic [10:0]         reg_width  = RST_IMG_WIDTH;
  logic [10:0]         reg_height = RST_IMG_HEIGHT;
  logic [2:0]          reg_chan   = RST_CHANNELS;
  logic [SAMPLE_W-1:0] line_mem [0:2*LINE_HALF-1];
  int unsigned         col_pos    = 0;
  int unsigned         row_pos    = 0;
  bit                  bank       = 1'b0;

  sharp_res_t          sharp_q[$];   // results still owed by the core
  logic [SAMPLE_W-1:0] feed_q[$];    // samples not yet presented

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_bad      = 0;
  int n_cfg      = 0;
  int n_cycles   = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit in_taken = 1'b0;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo,
                                            int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // out-of-range register values saturate into the used range
  task automatic eff_geometry(output int unsigned w, output int unsigned h,
                              output int unsigned c);
    w = clamp_reg(32'(reg_width), 3, LSH_MAX_WIDTH);
    h = clamp_reg(32'(reg_height), 3, LSH_MAX_HEIGHT);
    c = clamp_reg(32'(reg_chan), 1, LSH_MAX_CHANNELS);
  endtask

  function automatic int line_at(bit b, int unsigned idx);
    return int'(line_mem[int'(b) * LINE_HALF + idx]);
  endfunction

  // One accepted sample: the result for the row above at the same place, and
  // on the last row a second zero result for its own place.
  task automatic predict_sample(input logic [SAMPLE_W-1:0] px);
    int unsigned w, h, c, row_len, s, r;
    int ctr, lft, rgt, up, v;
    sharp_res_t res;
    eff_geometry(w, h, c);
    row_len = w * c;
    s = (col_pos >= row_len) ? row_len - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    if (r >= 1) begin
      res = '0;
      // interior only: border rows and pixel columns stay zero
      if (r >= 2 && s >= c && s < row_len - c) begin
        ctr = line_at(!bank, s);
        lft = line_at(!bank, s - c);
        rgt = line_at(!bank, s + c);
        up  = line_at(bank, s);
        v   = SHARP_GAIN * ctr - (lft + rgt + up + int'(px));
        res.sample = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
      sharp_q.push_back(res);
      if (r == h - 1) begin
        res.sample = '0;
        res.last   = (s == row_len - 1);
        sharp_q.push_back(res);
      end
    end
    line_mem[int'(bank) * LINE_HALF + s] = px;
    if (s + 1 >= row_len) begin
      col_pos = 0;
      if (r + 1 >= h) begin
        row_pos = 0;
        bank    = 1'b0;
      end else begin
        row_pos = r + 1;
        bank    = !bank;
      end
    end else begin
      col_pos = s + 1;
      row_pos = r;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued samples at the falling edge, random source gaps
  // only between items; the sink side stalls at random
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (feed_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= feed_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: input items feed the predictor, output items are checked in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    sharp_res_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_sample(in_tdata);
      n_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (sharp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= SHOW_MAX)
          $display("result %0d unexpected: sample %0d last %b",
                   n_checked, out_tdata, out_tlast);
      end else begin
        want = sharp_q.pop_front();
        if (want.sample !== out_tdata || want.last !== out_tlast) begin
          n_bad++;
          if (n_bad <= SHOW_MAX)
            $display("result %0d: sample exp %0d got %0d, last exp %b got %b",
                     n_checked, want.sample, out_tdata, want.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // all samples taken, all results in, then let first-row items leave the pipe
  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_pushed || sharp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMG_WIDTH:  reg_width  = val;
      CFG_IMG_HEIGHT: reg_height = val;
      CFG_CHANNELS:   reg_chan   = val[2:0];
      default:        ;
    endcase
    // a real register write restarts the frame, line banks keep their data
    if (idx != CFG_SPARE) begin
      col_pos = 0;
      row_pos = 0;
      bank    = 1'b0;
    end
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [10:0] w_raw, input logic [10:0] h_raw,
                              input logic [10:0] c_data);
    wait_idle();
    write_reg(CFG_IMG_WIDTH, w_raw);
    write_reg(CFG_IMG_HEIGHT, h_raw);
    write_reg(CFG_CHANNELS, c_data);
  endtask

  task automatic push_px(input logic [SAMPLE_W-1:0] px);
    feed_q.push_back(px);
    n_pushed++;
  endtask

  // styles: uniform, saturated black/white, bright with dark specks
  task automatic push_samples(input int unsigned k, input int unsigned style);
    for (int unsigned i = 0; i < k; i++) begin
      case (style)
        1:       push_px($urandom_range(0, 1) ? 8'd255 : 8'd0);
        2:       push_px(8'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(200, 255)));
        default: push_px(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic full_frames(input int unsigned frames, input int unsigned style);
    int unsigned w, h, c;
    eff_geometry(w, h, c);
    push_samples(frames * w * h * c, style);
  endtask

  // Small random geometry, mostly whole frames, sometimes two back to back,
  // sometimes cut short, sometimes paused for a write to the unused index.
  task automatic random_segment(output int unsigned k);
    logic [10:0] w_raw, h_raw, c_data;
    int unsigned w, h, c, n, split, style;
    w_raw = 11'($urandom_range(3, 10));
    if ($urandom_range(0, 15) == 0) w_raw = 11'($urandom_range(0, 2));
    h_raw = 11'($urandom_range(3, 7));
    if ($urandom_range(0, 15) == 0) h_raw = 11'($urandom_range(0, 2));
    c_data = 11'($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0)
      c_data = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(5, 7));
    // bits above the channel field are don't-care
    if ($urandom_range(0, 3) == 0) c_data[10:3] = 8'($urandom);
    set_geometry(w_raw, h_raw, c_data);
    eff_geometry(w, h, c);
    n = w * h * c;
    case ($urandom_range(0, 6))
      0:       k = 2 * n;
      1:       k = $urandom_range(1, n - 1);
      default: k = n;
    endcase
    style = $urandom_range(0, 2);
    split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, k - 1) : 0;
    if (split != 0) begin
      push_samples(split, style);
      wait_idle();
      write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      push_samples(k - split, style);
    end else begin
      push_samples(k, style);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k, done;
    logic [SAMPLE_W-1:0] directed [0:26] = '{
      // lone bright center: 5*255 clamps high
      8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
      // dark center in white: clamps to zero
      8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
      // unclamped: 5*100 - (50 + 60 + 70 + 80) = 240
      8'd9,   8'd50,  8'd7,   8'd60,  8'd100, 8'd70,  8'd3,   8'd80,  8'd200
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry 640x480x1: part of the first row, no results yet
    push_samples(24, 0);

    // three 3x3 frames back to back, wrapping the frame twice
    set_geometry(11'd3, 11'd3, 11'd1);
    foreach (directed[i]) push_px(directed[i]);

    // values below range clamp to 3x3x1; one frame then a cut-off restart
    set_geometry(11'd0, 11'd1, 11'd0);
    full_frames(1, 0);
    push_samples(4, 0);
    // 2 -> 3 wide, 2047 -> 1024 high, 7 -> 4 channels: a few rows only
    set_geometry(11'd2, 11'd2047, 11'd7);
    push_samples(60, 0);
    // 2047 -> 1024 pixels of 4 channels: part of the first row only
    set_geometry(11'd2047, 11'd3, 11'd5);
    push_samples(40, 2);
    set_geometry(11'd3, 11'd3, 11'd4);
    full_frames(2, 1);

    // random frames under each pressure mode
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_segment(k);
        done += k;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("sharpen run: %0d samples in, %0d results checked, %0d register writes",
             n_pushed, n_checked, n_cfg);
    $display("frames from 3x3 up to 10x7, 1-4 channels, clamped values, %s",
             "four pressure modes");
    if (n_bad == 0 && sharp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_bad, sharp_q.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
